[hdl/bss_pkg.sv]
package bss_pkg;

  localparam int WordBits = 32;
  localparam int RowW     = 12;
  localparam int IdxW     = 7;
  localparam int DimW     = 13;
  localparam int MaxDim   = 4096;
  localparam int TdataW   = 56;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegShiftX = 2'd2,
    RegShiftY = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        [DimW-1:0] width;
    logic        [DimW-1:0] height;
    logic signed [DimW-1:0] shift_x;
    logic signed [DimW-1:0] shift_y;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0]     row;
    logic [IdxW-1:0]     idx;
    logic [WordBits-1:0] cur;
    logic [WordBits-1:0] prev;
  } item_t;

  typedef struct packed {
    logic [RowW-1:0]     row;
    logic [IdxW-1:0]     idx;
    logic [WordBits-1:0] word;
    logic                last;
  } res_t;

endpackage

[hdl/bss_cfg_regs.sv]
module bss_cfg_regs import bss_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  reg_idx_e        cfg_idx_i,
  input  logic [DimW-1:0] cfg_data_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWidth:  cfg_d.width   = cfg_data_i;
        RegHeight: cfg_d.height  = cfg_data_i;
        RegShiftX: cfg_d.shift_x = cfg_data_i;
        RegShiftY: cfg_d.shift_y = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width   <= DimW'(1);
      cfg_q.height  <= DimW'(1);
      cfg_q.shift_x <= '0;
      cfg_q.shift_y <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/bss_in_reg.sv]
module bss_in_reg import bss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RowW-1:0]     in_row_i,
  input  logic [IdxW-1:0]     in_idx_i,
  input  logic [WordBits-1:0] in_word_i,
  output logic                item_valid_o,
  input  logic                item_take_i,
  output item_t               item_o
);

  logic                valid_q, valid_d;
  logic [WordBits-1:0] prev_q;
  item_t               item_q;
  logic                accept;

  assign in_ready_o = !valid_q || item_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign valid_d    = accept || (valid_q && !item_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prev_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (accept) prev_q <= in_word_i;
    end
  end

  // previous word reads as zero at row start
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.row  <= in_row_i;
      item_q.idx  <= in_idx_i;
      item_q.cur  <= in_word_i;
      item_q.prev <= (in_idx_i == '0) ? '0 : prev_q;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[hdl/bss_calc.sv]
module bss_calc import bss_pkg::*; (
  input  cfg_t       cfg_i,
  input  item_t      item_i,
  output logic [1:0] cnt_o,
  output res_t       res0_o,
  output res_t       res1_o
);

  logic [DimW-1:0]       w, h, abs_x, abs_y;
  logic [DimW:0]         nw_sum;
  logic [7:0]            nw, mo, k8;
  logic [8:0]            k_mo;
  logic [4:0]            s;
  logic signed [DimW:0]  r;
  logic                  keep, tail;
  logic [2*WordBits-1:0] fun_l, fun_r;
  logic [IdxW-1:0]       idx_pos, idx_neg, idx_neg1;

  assign w = (cfg_i.width  > DimW'(MaxDim)) ? DimW'(MaxDim) : cfg_i.width;
  assign h = (cfg_i.height > DimW'(MaxDim)) ? DimW'(MaxDim) : cfg_i.height;
  assign abs_x = cfg_i.shift_x[DimW-1] ? DimW'(~cfg_i.shift_x + 1'b1) : cfg_i.shift_x;
  assign abs_y = cfg_i.shift_y[DimW-1] ? DimW'(~cfg_i.shift_y + 1'b1) : cfg_i.shift_y;

  assign r = $signed({2'b00, item_i.row}) + $signed({cfg_i.shift_y[DimW-1], cfg_i.shift_y});

  assign nw_sum = {1'b0, w} + (DimW+1)'(WordBits - 1);
  assign nw     = nw_sum[DimW-1:5];
  assign mo     = abs_x[DimW-1:5];
  assign s      = abs_x[4:0];
  assign k8     = {1'b0, item_i.idx};
  assign k_mo   = {1'b0, k8} + {1'b0, mo};

  assign keep = (abs_x < w) && (abs_y < h) && ({1'b0, item_i.row} < h)
             && !r[DimW] && (r[DimW-1:0] < h) && (k8 < nw);

  assign fun_l = {item_i.cur, item_i.prev} << s;
  assign fun_r = {item_i.cur, item_i.prev} >> s;

  assign idx_pos  = k_mo[IdxW-1:0];
  assign idx_neg  = IdxW'(k8 - mo);
  assign idx_neg1 = IdxW'(k8 - mo - 8'd1);
  assign tail     = (k8 == nw - 8'd1) && (k8 >= mo);

  always_comb begin
    cnt_o       = 2'd0;
    res0_o.row  = r[RowW-1:0];
    res0_o.idx  = idx_pos;
    res0_o.word = fun_l[2*WordBits-1:WordBits];
    res0_o.last = 1'b1;
    res1_o.row  = r[RowW-1:0];
    res1_o.idx  = idx_neg;
    res1_o.word = item_i.cur >> s;
    res1_o.last = 1'b1;
    if (keep) begin
      if (!cfg_i.shift_x[DimW-1]) begin
        if (k_mo < {1'b0, nw}) cnt_o = 2'd1;
      end else if (s == '0) begin
        res0_o.idx  = idx_neg;
        res0_o.word = item_i.cur;
        if (k8 >= mo) cnt_o = 2'd1;
      end else if (k8 > mo) begin
        res0_o.idx  = idx_neg1;
        res0_o.word = fun_r[WordBits-1:0];
        res0_o.last = !tail;
        cnt_o       = tail ? 2'd2 : 2'd1;
      end else if (tail) begin
        res0_o = res1_o;
        cnt_o  = 2'd1;
      end
    end
  end

endmodule

[hdl/bss_out_buf.sv]
module bss_out_buf import bss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_valid_i,
  output logic       load_ok_o,
  input  logic [1:0] load_cnt_i,
  input  res_t       load_res0_i,
  input  res_t       load_res1_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_res_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       slot0_q, slot1_q;
  logic       load, pop;

  assign pop       = (cnt_q != 2'd0) && out_ready_i;
  assign load_ok_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign load      = load_valid_i && load_ok_o;

  always_comb begin
    cnt_d = cnt_q;
    if (load)     cnt_d = load_cnt_i;
    else if (pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else         cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot0_q <= load_res0_i;
      slot1_q <= load_res1_i;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign out_valid_o = cnt_q != 2'd0;
  assign out_res_o   = slot0_q;

endmodule

[hdl/bitmap_scanline_shift.sv]
// A result item passes the input register and then the result register before it
// is offered; the result register loads only when it is empty or is being emptied.
// Throughput: one input item per cycle while m_tready is high; an item that gives two
// results (row tail, unaligned leftward shift) holds the result register until both go.
// Reset: width and height 1, both shifts 0, previous word zero, no items in flight.
module bitmap_scanline_shift import bss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [DimW-1:0]   cfg_data_i,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [TdataW-1:0] s_tdata,   // src_row, src_word_index, src_word
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [TdataW-1:0] m_tdata,   // dest_row, dest_word_index, dest_word
  output logic              m_tlast
);

  cfg_t       cfg;
  item_t      item;
  logic       item_valid, load_ok;
  logic [1:0] cnt;
  res_t       res0, res1, out_res;

  bss_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (reg_idx_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bss_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid),
    .in_ready_o   (s_tready),
    .in_row_i     (s_tdata[RowW-1:0]),
    .in_idx_i     (s_tdata[RowW+IdxW-1:RowW]),
    .in_word_i    (s_tdata[RowW+IdxW+WordBits-1:RowW+IdxW]),
    .item_valid_o (item_valid),
    .item_take_i  (load_ok),
    .item_o       (item)
  );

  bss_calc u_calc (
    .cfg_i  (cfg),
    .item_i (item),
    .cnt_o  (cnt),
    .res0_o (res0),
    .res1_o (res1)
  );

  bss_out_buf u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (item_valid),
    .load_ok_o    (load_ok),
    .load_cnt_i   (cnt),
    .load_res0_i  (res0),
    .load_res1_i  (res1),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_res_o    (out_res)
  );

  assign m_tdata = {(TdataW-RowW-IdxW-WordBits)'(0), out_res.word, out_res.idx, out_res.row};
  assign m_tlast = out_res.last;

endmodule

[test/bitmap_scanline_shift_tb.sv]
module bitmap_scanline_shift_tb;
  import bss_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int ItemsTarget = 1050;
  localparam int SettleWait  = 6;

  typedef enum int {RxAlways, RxMostly, RxPattern, RxCoin} rx_mode_e;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              cfg_we_i   = 1'b0;
  logic [1:0]        cfg_idx_i  = '0;
  logic [DimW-1:0]   cfg_data_i = '0;
  logic              s_tvalid   = 1'b0;
  logic              s_tready;
  logic [TdataW-1:0] s_tdata    = '0;  // src_row, src_word_index, src_word
  logic              m_tvalid;
  logic              m_tready   = 1'b0;
  logic [TdataW-1:0] m_tdata;          // dest_row, dest_word_index, dest_word
  logic              m_tlast;

  // register shadow and scanline state
  int          cfg_width  = 1;
  int          cfg_height = 1;
  int          cfg_sx     = 0;
  int          cfg_sy     = 0;
  logic [31:0] prev_src_word = '0;

  res_t     dest_q[$];
  int       fail_count   = 0;
  int       items_sent   = 0;
  int       dest_checked = 0;
  int       reg_writes   = 0;
  int       idle_cycles  = 0;
  int       rx_tick      = 0;
  int       burst_left   = 0;
  bit       gaps_on      = 1'b1;
  rx_mode_e rx_mode      = RxCoin;

  bitmap_scanline_shift dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic void flag_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endfunction

  function automatic void expect_dest(input int r, input int k, input logic [31:0] w,
                                      input bit l);
    res_t e;
    e.row  = r[RowW-1:0];
    e.idx  = k[IdxW-1:0];
    e.word = w;
    e.last = l;
    dest_q.insert(dest_q.size(), e);
  endfunction

  // destination words produced by one source word
  task automatic predict_dest(input logic [RowW-1:0] row, input logic [IdxW-1:0] idx,
                              input logic [31:0] cur);
    int          w, h, nw, r, k, mo, s;
    logic [31:0] prev, dw;
    bit          tail;
    prev = (idx == '0) ? '0 : prev_src_word;
    prev_src_word = cur;
    w = (cfg_width > MaxDim) ? MaxDim : cfg_width;
    h = (cfg_height > MaxDim) ? MaxDim : cfg_height;
    if (cfg_sx <= -w || cfg_sx >= w || cfg_sy <= -h || cfg_sy >= h) return;
    r = int'(row) + cfg_sy;
    if (int'(row) >= h || r < 0 || r >= h) return;
    nw = (w + WordBits - 1) / WordBits;
    k = int'(idx);
    if (k >= nw) return;
    if (cfg_sx >= 0) begin
      mo = cfg_sx / WordBits;
      s  = cfg_sx % WordBits;
      if (k + mo >= nw) return;
      dw = (s == 0) ? cur : ((prev >> (WordBits - s)) | (cur << s));
      expect_dest(r, k + mo, dw, 1'b1);
    end else begin
      mo = (-cfg_sx) / WordBits;
      s  = (-cfg_sx) % WordBits;
      if (s == 0) begin
        if (k >= mo) expect_dest(r, k - mo, cur, 1'b1);
      end else begin
        tail = (k == nw - 1) && (k >= mo);
        if (k > mo) begin
          dw = (prev >> s) | (cur << (WordBits - s));
          expect_dest(r, k - 1 - mo, dw, !tail);
        end
        if (tail) expect_dest(r, nw - 1 - mo, cur >> s, 1'b1);
      end
    end
  endtask

  task automatic write_reg(input reg_idx_e ridx, input int val);
    logic [DimW-1:0] v;
    v = DimW'(val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ridx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (ridx)
      RegWidth:  cfg_width  = int'(v);
      RegHeight: cfg_height = int'(v);
      RegShiftX: cfg_sx     = $signed(v);
      RegShiftY: cfg_sy     = $signed(v);
    endcase
    reg_writes++;
  endtask

  task automatic send_src(input int row, input int idx, input logic [31:0] word);
    int              gap;
    logic [RowW-1:0] r;
    logic [IdxW-1:0] k;
    r   = RowW'(row);
    k   = IdxW'(idx);
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 5);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      @(negedge clk_i) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TdataW - RowW - IdxW - WordBits){1'b0}}, word, k, r};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_dest(r, k, word);
    items_sent++;
  endtask

  // sender holds off until every expected item is in, then lets the pipe settle
  task automatic wait_idle();
    @(negedge clk_i) s_tvalid <= 1'b0;
    while (dest_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // mostly whole rows in order, landing inside the bitmap; some noise rows
  task automatic send_random_rows(input int budget);
    int          w, h, nw, lo, hi, n, row;
    bit          noisy;
    logic [31:0] word;
    w  = (cfg_width > MaxDim) ? MaxDim : cfg_width;
    h  = (cfg_height > MaxDim) ? MaxDim : cfg_height;
    nw = (w + WordBits - 1) / WordBits;
    lo = (cfg_sy < 0) ? -cfg_sy : 0;
    hi = (cfg_sy > 0) ? h - 1 - cfg_sy : h - 1;
    while (budget > 0) begin
      if (lo <= hi && $urandom_range(0, 4) != 0) row = $urandom_range(lo, hi);
      else row = $urandom_range(0, 4095);
      noisy = ($urandom_range(0, 9) == 0);
      n = (nw == 0 || noisy) ? $urandom_range(1, 6) : nw;
      for (int k = 0; k < n && budget > 0; k++) begin
        case ($urandom_range(0, 7))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom();
        endcase
        send_src(row, noisy ? int'($urandom_range(0, 127)) : k, word);
        budget--;
      end
    end
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 11))
      0:       return MaxDim;
      1:       return $urandom_range(MaxDim + 1, 8191);
      2:       return 0;
      3:       return WordBits * $urandom_range(1, 8);
      4:       return 1;
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  function automatic int pick_offset(input int lim);
    if (lim == 0) return $urandom_range(0, 8191) - 4096;
    case ($urandom_range(0, 9))
      0:       return lim - 1;
      1:       return 1 - lim;
      2:       return ($urandom_range(0, 1) ? -1 : 1) * WordBits
                      * $urandom_range(0, (lim - 1) / WordBits);
      3:       return $urandom_range(0, 1) ? -4096 : ((lim < MaxDim) ? lim : 4095);
      4:       return 0;
      default: return $urandom_range(0, 2 * lim - 2) - (lim - 1);
    endcase
  endfunction

  task automatic test_reset_state();
    send_src(0, 0, 32'hFFFF_FFFF);
    send_src(1, 0, $urandom());
    send_src(0, 1, $urandom());
  endtask

  task automatic test_word_shifts();
    wait_idle();
    write_reg(RegWidth, 100);
    write_reg(RegHeight, 4096);
    write_reg(RegShiftY, 0);
    write_reg(RegShiftX, 5);
    send_src(4095, 0, 32'hFFFF_FFFF);
    send_src(4095, 1, '0);
    send_src(4095, 2, 32'hA5A5_A5A5);
    send_src(4095, 3, $urandom());
    wait_idle();
    write_reg(RegShiftX, -37);  // unaligned left, row tail gives two items
    for (int k = 0; k < 4; k++) send_src(7, k, $urandom());
    wait_idle();
    write_reg(RegShiftX, -64);
    for (int k = 0; k < 4; k++) send_src(3, k, $urandom());
    wait_idle();
    write_reg(RegShiftX, 32);
    write_reg(RegShiftY, -1);
    send_src(0, 0, $urandom());
    send_src(1, 0, $urandom());
  endtask

  task automatic test_offset_limits();
    wait_idle();
    write_reg(RegShiftX, 100);
    send_src(5, 0, $urandom());
    wait_idle();
    write_reg(RegShiftX, 0);
    write_reg(RegWidth, 0);
    send_src(5, 0, $urandom());
  endtask

  task automatic test_oversized();
    wait_idle();
    write_reg(RegWidth, 8191);
    write_reg(RegHeight, 8191);
    write_reg(RegShiftX, -4096);
    write_reg(RegShiftY, 4095);
    send_src(0, 127, '1);
    wait_idle();
    write_reg(RegShiftX, 0);
    send_src(0, 127, $urandom());
  endtask

  task automatic test_word_order();
    wait_idle();
    write_reg(RegWidth, 100);
    write_reg(RegHeight, 16);
    write_reg(RegShiftX, 3);
    write_reg(RegShiftY, 0);
    send_src(2, 0, $urandom());
    send_src(2, 2, $urandom());
    send_src(2, 2, $urandom());
    send_src(2, 1, $urandom());
  endtask

  task automatic test_pause_until_drained();
    wait_idle();
    write_reg(RegWidth, 200);
    write_reg(RegHeight, 16);
    write_reg(RegShiftX, -45);
    write_reg(RegShiftY, 3);
    rx_mode = RxPattern;
    send_random_rows(14);
    wait_idle();
    send_random_rows(14);
  endtask

  task automatic test_random_scroll();
    int wv, hv, sx, sy;
    for (int ph = 0; items_sent < ItemsTarget; ph++) begin
      wait_idle();
      case (ph)
        0: begin wv = 4096; hv = 4096; sx = 4095;  sy = -4095; end
        1: begin wv = 8191; hv = 8191; sx = -4095; sy = 4095;  end
        2: begin wv = 1;    hv = 1;    sx = 0;     sy = 0;     end
        3: begin wv = 33;   hv = 3;    sx = -32;   sy = -2;    end
        default: begin
          wv = pick_dim();
          hv = pick_dim();
          sx = pick_offset((wv > MaxDim) ? MaxDim : wv);
          sy = pick_offset((hv > MaxDim) ? MaxDim : hv);
        end
      endcase
      write_reg(RegWidth, wv);
      write_reg(RegHeight, hv);
      write_reg(RegShiftX, sx);
      write_reg(RegShiftY, sy);
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random_rows($urandom_range(40, 120));
    end
  endtask

  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RxAlways:  m_tready <= 1'b1;
      RxMostly:  m_tready <= ($urandom_range(0, 3) != 0);
      RxPattern: m_tready <= (rx_tick % 5 != 4);
      default:   m_tready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk_i) begin : check_dest
    res_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.row  = m_tdata[RowW-1:0];
      got.idx  = m_tdata[RowW +: IdxW];
      got.word = m_tdata[RowW + IdxW +: WordBits];
      got.last = m_tlast;
      dest_checked++;
      if (dest_q.size() == 0) begin
        flag_failure($sformatf("unexpected item: row %0d word %0d data %h last %b",
                               got.row, got.idx, got.word, got.last));
      end else begin
        want = dest_q.pop_front();
        if (got !== want)
          flag_failure($sformatf({"mismatch: expected row %0d word %0d data %h last %b,",
                                  " got row %0d word %0d data %h last %b"},
                                 want.row, want.idx, want.word, want.last,
                                 got.row, got.idx, got.word, got.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("no handshake for %0d cycles, %0d items outstanding", IdleLimit,
               dest_q.size());
      $display("** bitmap_scanline_shift: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_reset_state();
    test_word_shifts();
    test_offset_limits();
    test_oversized();
    test_word_order();
    test_pause_until_drained();
    test_random_scroll();
    wait_idle();
    if (dest_q.size() != 0)
      flag_failure($sformatf("%0d expected items never arrived", dest_q.size()));
    $display("Scrolled %0d source words across %0d register writes;", items_sent,
             reg_writes);
    $display("%0d destination words checked, %0d failures.", dest_checked, fail_count);
    if (fail_count == 0) begin
      $display("** bitmap_scanline_shift: PASSED **");
    end else begin
      $display("** bitmap_scanline_shift: FAILED **");
    end
    $finish;
  end

endmodule

[bitmap_scanline_shift.f]
hdl/bss_pkg.sv
hdl/bss_cfg_regs.sv
hdl/bss_in_reg.sv
hdl/bss_calc.sv
hdl/bss_out_buf.sv
hdl/bitmap_scanline_shift.sv
test/bitmap_scanline_shift_tb.sv
